>>> sv/sfir_pkg.sv
// ----------------------------------------------------------------------------
// sfir_pkg
// Shared constants, register indexes and controller/datapath interface types
// for the symmetric FIR filter.
// ----------------------------------------------------------------------------
package sfir_pkg;

    localparam int MAX_TAPS_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 16;
    localparam int COEF_WIDTH_DEF = 16;

    localparam int TAP_COUNT_W  = 7;
    localparam int COEF_INDEX_W = 5;
    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = 8;

    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = TAP_COUNT_W'(64);

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TAP_COUNT  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_ODD_LENGTH = CFG_INDEX_W'(1);

    // item kinds carried on s_tuser
    localparam logic MODE_FILTER    = 1'b0;
    localparam logic MODE_COEF_LOAD = 1'b1;

    typedef struct packed {
        logic start;     // sample transfer: write delay line, set up the run
        logic coef_wr;   // coefficient transfer
        logic issue;     // issue one folded tap
        logic load_out;  // round, saturate and load the output register
    } sfir_cmd_t;

    typedef struct packed {
        logic last_issue;
        logic pipe_busy;
        logic out_full;
    } sfir_status_t;

endpackage

>>> sv/sfir_ctrl.sv
// ----------------------------------------------------------------------------
// sfir_ctrl
// Sequencer for the symmetric FIR filter: accepts items, steps the folded
// multiply-accumulate and hands the result to the output register.
// ----------------------------------------------------------------------------
module sfir_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  mode,
    output sfir_pkg::sfir_cmd_t   cmd,
    input  sfir_pkg::sfir_status_t status
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_OUTPUT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next   = state_reg;
        cmd.start    = 1'b0;
        cmd.coef_wr  = 1'b0;
        cmd.issue    = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (mode == sfir_pkg::MODE_COEF_LOAD) begin
                        cmd.coef_wr = 1'b1;
                    end else begin
                        cmd.start  = 1'b1;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                cmd.issue = 1'b1;
                if (status.last_issue) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                // wait for the previous result to be taken
                if (!status.out_full) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/sfir_datapath.sv
// ----------------------------------------------------------------------------
// sfir_datapath
// Delay-line and coefficient memories, folded pre-add / multiply /
// accumulate pipeline, rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module sfir_datapath #(
    parameter int MAX_TAPS   = sfir_pkg::MAX_TAPS_DEF,
    parameter int DATA_WIDTH = sfir_pkg::DATA_WIDTH_DEF,
    parameter int COEF_WIDTH = sfir_pkg::COEF_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [sfir_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [sfir_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic signed [DATA_WIDTH-1:0]          sample,
    input  logic [sfir_pkg::COEF_INDEX_W-1:0]     coef_index,
    input  logic signed [COEF_WIDTH-1:0]          coef_value,
    input  sfir_pkg::sfir_cmd_t                   cmd,
    output sfir_pkg::sfir_status_t                status,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic signed [DATA_WIDTH-1:0]          filtered,
    output logic                                  saturated
);

    localparam int HALF_TAPS = (MAX_TAPS + 1) / 2;
    localparam int CA_W      = (HALF_TAPS > 1) ? $clog2(HALF_TAPS) : 1;
    localparam int DA_W      = $clog2(MAX_TAPS);
    localparam int LEN_W     = $clog2(MAX_TAPS + 1);
    localparam int SW        = $clog2(HALF_TAPS + 1);
    localparam int TW        = (LEN_W > sfir_pkg::TAP_COUNT_W) ? LEN_W
                                                              : sfir_pkg::TAP_COUNT_W;
    localparam int PRE_W     = DATA_WIDTH + 1;
    localparam int PROD_W    = PRE_W + COEF_WIDTH;
    localparam int ACC_W     = PROD_W + SW;
    localparam int SH        = COEF_WIDTH - 1;
    localparam int RW        = ACC_W - SH;
    localparam int AW        = LEN_W + 1;

    // configuration registers
    logic [sfir_pkg::TAP_COUNT_W-1:0] tap_count_reg;
    logic                             odd_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg  <= sfir_pkg::TAP_COUNT_RESET;
            odd_length_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sfir_pkg::REG_TAP_COUNT:  tap_count_reg  <= cfg_data[sfir_pkg::TAP_COUNT_W-1:0];
                sfir_pkg::REG_ODD_LENGTH: odd_length_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // run setup: clamp the tap count and derive the folded step count
    logic [TW-1:0]    t_clamp;
    logic [TW-1:0]    half_c;
    logic [LEN_W-1:0] len_next;
    logic [SW-1:0]    steps_next;

    always_comb begin
        t_clamp = TW'(tap_count_reg);
        if (t_clamp < TW'(2)) begin
            t_clamp = TW'(2);
        end
        if (t_clamp > TW'(MAX_TAPS)) begin
            t_clamp = TW'(MAX_TAPS);
        end
        half_c = odd_length_reg ? ((t_clamp - TW'(1)) >> 1) : (t_clamp >> 1);
        len_next   = LEN_W'({half_c, odd_length_reg});
        steps_next = SW'(half_c + TW'(odd_length_reg));
    end

    logic [SW-1:0]    c_reg;
    logic [SW-1:0]    steps_reg;
    logic [LEN_W-1:0] len_reg;
    logic             odd_reg;
    logic [SW-1:0]    j_reg;
    logic [DA_W-1:0]  newest_reg;
    logic [LEN_W-1:0] fill_reg;

    logic [DA_W-1:0]  newest_next;
    assign newest_next = (newest_reg == DA_W'(MAX_TAPS - 1)) ? '0 : newest_reg + DA_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j_reg      <= '0;
            newest_reg <= '0;
            fill_reg   <= '0;
        end else if (cmd.start) begin
            j_reg      <= '0;
            newest_reg <= newest_next;
            if (fill_reg != LEN_W'(MAX_TAPS)) begin
                fill_reg <= fill_reg + LEN_W'(1);
            end
        end else if (cmd.issue) begin
            j_reg <= j_reg + SW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            c_reg     <= SW'(half_c);
            steps_reg <= steps_next;
            len_reg   <= len_next;
            odd_reg   <= odd_length_reg;
        end
    end

    // sample ages of the folded pair and their circular-buffer addresses
    logic [LEN_W-1:0] age_a;
    logic [LEN_W-1:0] age_b;
    logic [AW-1:0]    diff_a;
    logic [AW-1:0]    diff_b;
    logic [DA_W-1:0]  addr_a;
    logic [DA_W-1:0]  addr_b;
    logic             centre;

    always_comb begin
        age_a  = LEN_W'(j_reg);
        age_b  = len_reg - LEN_W'(1) - LEN_W'(j_reg);
        diff_a = AW'(newest_reg) - AW'(age_a);
        if (AW'(newest_reg) < AW'(age_a)) begin
            diff_a = diff_a + AW'(MAX_TAPS);
        end
        diff_b = AW'(newest_reg) - AW'(age_b);
        if (AW'(newest_reg) < AW'(age_b)) begin
            diff_b = diff_b + AW'(MAX_TAPS);
        end
        addr_a = diff_a[DA_W-1:0];
        addr_b = diff_b[DA_W-1:0];
        centre = odd_reg && (j_reg == c_reg);
    end

    // memories
    logic signed [DATA_WIDTH-1:0] dl_mem [MAX_TAPS];
    logic signed [COEF_WIDTH-1:0] coef_mem [HALF_TAPS];

    logic signed [DATA_WIDTH-1:0] rd_a_reg;
    logic signed [DATA_WIDTH-1:0] rd_b_reg;
    logic signed [COEF_WIDTH-1:0] coef_rd_reg;
    logic                         use_a_reg;
    logic                         use_b_reg;

    logic [31:0]     coef_index_ext;
    logic [CA_W-1:0] coef_waddr;
    assign coef_index_ext = 32'(coef_index);
    assign coef_waddr     = coef_index_ext[CA_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            dl_mem[newest_next] <= sample;
        end
        if (cmd.issue) begin
            rd_a_reg <= dl_mem[addr_a];
            rd_b_reg <= dl_mem[addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.coef_wr && (coef_index_ext < 32'(HALF_TAPS))) begin
            coef_mem[coef_waddr] <= coef_value;
        end
        if (cmd.issue) begin
            coef_rd_reg <= coef_mem[j_reg[CA_W-1:0]];
        end
    end

    // samples older than the number written since reset read as zero
    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            use_a_reg <= age_a < fill_reg;
            use_b_reg <= (age_b < fill_reg) && !centre;
        end
    end

    // pipeline: read -> pre-add and multiply -> accumulate
    logic v1_reg;
    logic v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
        end
    end

    logic signed [PRE_W-1:0]  pre_sum;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    always_comb begin
        pre_sum = (use_a_reg ? PRE_W'(rd_a_reg) : '0) + (use_b_reg ? PRE_W'(rd_b_reg) : '0);
    end

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            prod_reg <= pre_sum * PROD_W'(coef_rd_reg);
        end
        if (cmd.start) begin
            acc_reg <= '0;
        end else if (v2_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // round half up, drop the coefficient fraction, saturate
    logic signed [ACC_W-1:0]      acc_rnd;
    logic signed [RW-1:0]         rnd;
    logic [RW-DATA_WIDTH:0]       rnd_top;
    logic                         sat;
    logic signed [DATA_WIDTH-1:0] y;

    always_comb begin
        acc_rnd = acc_reg + (ACC_W'(1) <<< (SH - 1));
        rnd     = RW'(acc_rnd >>> SH);
        rnd_top = rnd[RW-1:DATA_WIDTH-1];
        sat     = !((&rnd_top) || !(|rnd_top));
        if (!sat) begin
            y = rnd[DATA_WIDTH-1:0];
        end else if (rnd[RW-1]) begin
            y = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            y = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    end

    // output register
    logic                         out_valid_reg;
    logic signed [DATA_WIDTH-1:0] filtered_reg;
    logic                         saturated_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            filtered_reg  <= y;
            saturated_reg <= sat;
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign filtered  = filtered_reg;
    assign saturated = saturated_reg;

    assign status.last_issue = (j_reg == steps_reg - SW'(1));
    assign status.pipe_busy  = v1_reg || v2_reg;
    assign status.out_full   = out_valid_reg && !m_tready;

endmodule

>>> sv/symmetric_fir_filter.sv
// ----------------------------------------------------------------------------
// symmetric_fir_filter
// Linear-phase FIR filter storing half of a symmetric impulse response,
// folded into one pre-add multiply-accumulate per coefficient pair.
//
//   channel   direction  payload
//   s_*       in         tuser: mode; tdata: sample, coef_index, coef_value
//   m_*       out        tuser: saturated; tdata: filtered
//   cfg_*     in         cfg_index: register, cfg_data: value
//
// A coefficient load is written when it is accepted. A sample is accepted,
// then each folded tap is issued in turn, the MAC pipeline drains and the
// output register is loaded; no new item is accepted until the sample is done.
// Reset clears the delay line through a fill count; no clearing pass.
// A result waiting on m_tready stalls only the final load of the next one.
// ----------------------------------------------------------------------------
module symmetric_fir_filter #(
    parameter int MAX_TAPS   = sfir_pkg::MAX_TAPS_DEF,
    parameter int DATA_WIDTH = sfir_pkg::DATA_WIDTH_DEF,
    parameter int COEF_WIDTH = sfir_pkg::COEF_WIDTH_DEF,
    localparam int S_TDATA_W = ((DATA_WIDTH + sfir_pkg::COEF_INDEX_W + COEF_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [S_TDATA_W-1:0]             s_tdata,   // sample, coef_index, coef_value
    input  logic                             s_tuser,   // mode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [M_TDATA_W-1:0]             m_tdata,   // filtered
    output logic                             m_tuser,   // saturated
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sfir_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sfir_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CI_LO = DATA_WIDTH;
    localparam int CV_LO = DATA_WIDTH + sfir_pkg::COEF_INDEX_W;

    sfir_pkg::sfir_cmd_t    cmd;
    sfir_pkg::sfir_status_t status;

    logic signed [DATA_WIDTH-1:0]         sample;
    logic [sfir_pkg::COEF_INDEX_W-1:0]    coef_index;
    logic signed [COEF_WIDTH-1:0]         coef_value;
    logic signed [DATA_WIDTH-1:0]         filtered;

    assign sample     = s_tdata[DATA_WIDTH-1:0];
    assign coef_index = s_tdata[CV_LO-1:CI_LO];
    assign coef_value = s_tdata[CV_LO+COEF_WIDTH-1:CV_LO];

    assign cfg_ready = 1'b1;
    assign m_tdata   = M_TDATA_W'($unsigned(filtered));

    sfir_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (s_tuser),
        .cmd      (cmd),
        .status   (status)
    );

    sfir_datapath #(
        .MAX_TAPS   (MAX_TAPS),
        .DATA_WIDTH (DATA_WIDTH),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample     (sample),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .cmd        (cmd),
        .status     (status),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .filtered   (filtered),
        .saturated  (m_tuser)
    );

endmodule
